// File: rtl/trapezoid_profile_position_macros.svh
// assertion macros used by the checker file of the trapezoid profile block
`ifndef TRAPEZOID_PROFILE_POSITION_MACROS_SVH
`define TRAPEZOID_PROFILE_POSITION_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define TPP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define TPP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/trp_pkg.sv
// shared types and constants of the trapezoid profile position block
package trp_pkg;

  // result scaling: Q1.16 position, 65536 stands for 1.0
  localparam int OUT_FRAC = 16;
  localparam int QUO_BITS = OUT_FRAC + 1;
  localparam logic [QUO_BITS-1:0] OUT_ONE = QUO_BITS'(1) << OUT_FRAC;

  // widths of the products in the front stages
  localparam int OPND_W = 32;
  localparam int SQ_W   = 2 * OPND_W;
  localparam int PROD_W = OPND_W + SQ_W;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_VELOCITY = 2'd0;
  localparam logic [1:0] REG_RAMP_TIME    = 2'd1;
  localparam logic [1:0] REG_PATH_LENGTH  = 2'd2;
  localparam logic [1:0] REG_TOTAL_TIME   = 2'd3;

  // phase codes reported with each result
  typedef enum logic [2:0] {
    PH_ACCEL   = 3'd0,
    PH_CRUISE  = 3'd1,
    PH_DECEL   = 3'd2,
    PH_OUTSIDE = 3'd3,
    PH_INVALID = 3'd4
  } phase_t;

  // control that travels with an item through the divider
  typedef struct packed {
    logic   valid;
    phase_t phase;
  } trp_ctl_t;

endpackage

// File: rtl/trp_stream_if.sv
// valid/ready channels for time samples and position results
interface trp_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink (input valid, input sample_time, output ready);
endinterface

interface trp_result_if;
  logic        valid;
  logic        ready;
  logic [16:0] position_fraction;
  logic [2:0]  phase;

  modport source (output valid, output position_fraction, output phase, input ready);
  modport sink (input valid, input position_fraction, input phase, output ready);
endinterface

// File: rtl/trapezoid_profile_position.sv
// top level: trapezoidal velocity profile, normalized path position per time sample
// throughput: one sample per cycle; 22 pipeline stages (4 front, 18 divider) plus a
// two-entry output queue, the whole pipeline holds only while that queue is full
// reset: clears valid bits, the output queue and all four registers to zero
module trapezoid_profile_position #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data,
  trp_sample_if.sink          sample,
  trp_result_if.source        result
);

  localparam int QB    = trp_pkg::QUO_BITS;
  localparam int NUM_W = trp_pkg::PROD_W + trp_pkg::OUT_FRAC;
  localparam int DEN_W = trp_pkg::SQ_W + FRAC_BITS + 1;

  // configuration registers
  logic [31:0] max_velocity;
  logic [31:0] ramp_time;
  logic [31:0] path_length;
  logic [31:0] end_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity <= '0;
      ramp_time    <= '0;
      path_length  <= '0;
      end_time     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        trp_pkg::REG_MAX_VELOCITY: max_velocity <= wr_data;
        trp_pkg::REG_RAMP_TIME:    ramp_time    <= wr_data;
        trp_pkg::REG_PATH_LENGTH:  path_length  <= wr_data;
        trp_pkg::REG_TOTAL_TIME:   end_time     <= wr_data;
      endcase
    end
  end

  // pipeline advance: held only while the output queue is full
  logic [1:0] count;
  logic       en;

  assign en           = (count != 2'd2);
  assign sample.ready = en;

  // stage 1: phase decision and operand selection
  logic [31:0]       t_bits;
  logic [32:0]       t_plus_ramp;
  trp_pkg::phase_t   phase_c;
  logic [31:0]       x_c;
  logic [31:0]       y_c;
  logic [31:0]       m_c;

  assign t_bits      = unsigned'(sample.sample_time);
  assign t_plus_ramp = {1'b0, t_bits} + {1'b0, ramp_time};

  always_comb begin
    phase_c = trp_pkg::PH_OUTSIDE;
    x_c     = '0;
    y_c     = '0;
    m_c     = '0;
    priority if (max_velocity == '0 || ramp_time == '0 || path_length == '0) begin
      phase_c = trp_pkg::PH_INVALID;
    end else if (t_bits[31]) begin
      phase_c = trp_pkg::PH_OUTSIDE;
    end else if (t_bits <= ramp_time) begin
      phase_c = trp_pkg::PH_ACCEL;
      x_c     = t_bits;
      y_c     = t_bits;
      m_c     = ramp_time;
    end else if (t_plus_ramp <= {1'b0, end_time}) begin
      phase_c = trp_pkg::PH_CRUISE;
      x_c     = {t_bits[30:0], 1'b0} - ramp_time;
      y_c     = 32'd1;
      m_c     = 32'd1;
    end else if (t_bits <= end_time) begin
      phase_c = trp_pkg::PH_DECEL;
      x_c     = end_time - t_bits;
      y_c     = end_time - t_bits;
      m_c     = ramp_time;
    end else begin
      phase_c = trp_pkg::PH_OUTSIDE;
    end
  end

  logic            s1_valid;
  trp_pkg::phase_t s1_phase;
  logic [31:0]     s1_x;
  logic [31:0]     s1_y;
  logic [31:0]     s1_m;

  // stage 2: square term and divisor product
  logic            s2_valid;
  trp_pkg::phase_t s2_phase;
  logic [63:0]     s2_sq;
  logic [63:0]     s2_rl;

  // stage 3: velocity times square term, as two partial products
  logic            s3_valid;
  trp_pkg::phase_t s3_phase;
  logic [63:0]     s3_plo;
  logic [63:0]     s3_phi;
  logic [63:0]     s3_rl;

  // stage 4: partial products summed
  logic                        s4_valid;
  trp_pkg::phase_t             s4_phase;
  logic [trp_pkg::PROD_W-1:0]  s4_num;
  logic [63:0]                 s4_rl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_phase <= phase_c;
      s1_x     <= x_c;
      s1_y     <= y_c;
      s1_m     <= m_c;

      s2_phase <= s1_phase;
      s2_sq    <= 64'(s1_x) * 64'(s1_y);
      s2_rl    <= 64'(s1_m) * 64'(path_length);

      s3_phase <= s2_phase;
      s3_plo   <= 64'(max_velocity) * 64'(s2_sq[31:0]);
      s3_phi   <= 64'(max_velocity) * 64'(s2_sq[63:32]);
      s3_rl    <= s2_rl;

      s4_phase <= s3_phase;
      s4_num   <= {s3_phi, 32'd0} + {32'd0, s3_plo};
      s4_rl    <= s3_rl;
    end
  end

  // divider: position = (num * 2^16) / (rl * 2^(FRAC_BITS+1))
  trp_pkg::trp_ctl_t ctl_in;
  trp_pkg::trp_ctl_t d_ctl;
  logic [NUM_W-1:0]  d_num;
  logic [DEN_W-1:0]  d_den;
  logic [QB-1:0]     d_quo;
  logic              d_ovf;

  assign ctl_in.valid = s4_valid;
  assign ctl_in.phase = s4_phase;
  assign d_num        = {s4_num, {trp_pkg::OUT_FRAC{1'b0}}};
  assign d_den        = {s4_rl, {(FRAC_BITS + 1){1'b0}}};

  trp_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_in),
    .num     (d_num),
    .den     (d_den),
    .ctl_out (d_ctl),
    .quo     (d_quo),
    .ovf     (d_ovf)
  );

  // saturation and final position per phase
  logic [QB-1:0] frac_sat;
  logic [QB-1:0] pos_c;

  assign frac_sat = (d_ovf || d_quo > trp_pkg::OUT_ONE) ? trp_pkg::OUT_ONE : d_quo;

  always_comb begin
    unique case (d_ctl.phase)
      trp_pkg::PH_ACCEL:   pos_c = frac_sat;
      trp_pkg::PH_CRUISE:  pos_c = frac_sat;
      trp_pkg::PH_DECEL:   pos_c = trp_pkg::OUT_ONE - frac_sat;
      trp_pkg::PH_OUTSIDE: pos_c = trp_pkg::OUT_ONE;
      trp_pkg::PH_INVALID: pos_c = '0;
      default:             pos_c = '0;
    endcase
  end

  // two-entry output queue
  logic [QB-1:0]   q_pos   [2];
  trp_pkg::phase_t q_phase [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic            push;
  logic            pop;
  logic [1:0]      count_next;

  assign push       = en && d_ctl.valid;
  assign pop        = result.valid && result.ready;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_pos[wr_ptr]   <= pos_c;
      q_phase[wr_ptr] <= d_ctl.phase;
    end
  end

  assign result.valid             = (count != 2'd0);
  assign result.position_fraction = q_pos[rd_ptr];
  assign result.phase             = q_phase[rd_ptr];

endmodule

// File: rtl/trp_divider.sv
// pipelined restoring divider: one quotient bit per stage, saturating overflow flag
module trp_divider #(
  parameter int NUM_W = 112,
  parameter int DEN_W = 81
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  trp_pkg::trp_ctl_t                ctl_in,
  input  logic [NUM_W-1:0]                 num,
  input  logic [DEN_W-1:0]                 den,
  output trp_pkg::trp_ctl_t                ctl_out,
  output logic [trp_pkg::QUO_BITS-1:0]     quo,
  output logic                             ovf
);

  localparam int QB = trp_pkg::QUO_BITS;
  localparam int W  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  trp_pkg::trp_ctl_t ctl_q [QB+1];
  logic [W-1:0]      rem   [QB+1];
  logic [W-1:0]      den_q [QB+1];
  logic [QB-1:0]     quo_q [QB+1];
  logic              ovf_q [QB+1];

  logic [W-1:0] num_ext;
  logic [W-1:0] den_ext;

  assign num_ext = W'(num);
  assign den_ext = W'(den);

  // entry stage: flag quotients that do not fit in the result bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[0] <= '0;
    end else if (en) begin
      ctl_q[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= num_ext;
      den_q[0] <= den_ext;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_ext >= (den_ext << QB));
    end
  end

  // one trial subtract per stage, most significant quotient bit first
  for (genvar k = 1; k <= QB; k++) begin : g_bit
    localparam int SH = QB - k;
    logic [W-1:0] trial;
    logic         fits;

    assign trial = den_q[k-1] << SH;
    assign fits  = (rem[k-1] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k] <= '0;
      end else if (en) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= fits ? (rem[k-1] - trial) : rem[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_q[k-1] | (fits ? (QB'(1) << SH) : QB'(0));
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign ctl_out = ctl_q[QB];
  assign quo     = quo_q[QB];
  assign ovf     = ovf_q[QB];

endmodule

// File: rtl/trp_checker.sv
// port-level checker for the trapezoid profile block and its bind
`include "trapezoid_profile_position_macros.svh"

module trp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] position_fraction,
  input logic [2:0]  phase
);

  // invalid configuration always reports position zero
  `TPP_ASSERT_IMP(a_invalid_zero, clk, rst, out_valid && phase == trp_pkg::PH_INVALID, position_fraction == 17'd0, "invalid phase with nonzero position")

  // outside the time span always reports the full path
  `TPP_ASSERT_IMP(a_outside_one, clk, rst, out_valid && phase == trp_pkg::PH_OUTSIDE, position_fraction == trp_pkg::OUT_ONE, "outside phase without full position")

  // every reported position stays within 0..1
  `TPP_ASSERT_IMP(a_pos_range, clk, rst, out_valid, position_fraction <= trp_pkg::OUT_ONE, "position above 1.0")

  // a stalled result holds its value
  `TPP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(position_fraction) && $stable(phase), "stalled result changed")

  // reset empties the output and leaves room for a new item
  `TPP_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !out_valid && in_ready, "result or stall present after reset")

endmodule

bind trapezoid_profile_position trp_checker u_trp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (sample.ready),
  .out_valid         (result.valid),
  .out_ready         (result.ready),
  .position_fraction (result.position_fraction),
  .phase             (result.phase)
);
